// ----- rtl/core/pee_pkg.sv -----
// Package for the prefix expression evaluator.
// Holds the shared widths, character and status codes, and the divider request type.
// Depends on nothing.
package pee_pkg;

    // Word and field widths.
    localparam int DATA_W          = 32;
    localparam int SYM_W           = 8;
    localparam int STAT_W          = 3;
    localparam int STACK_DEPTH_DEF = 32;

    // Character codes that the evaluator recognises.
    localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [SYM_W-1:0] CH_PCT   = 8'h25;

    // Status codes reported with each result word.
    localparam logic [STAT_W-1:0] ERR_NONE      = 3'd0;
    localparam logic [STAT_W-1:0] ERR_UNDERFLOW = 3'd1;
    localparam logic [STAT_W-1:0] ERR_OVERFLOW  = 3'd2;
    localparam logic [STAT_W-1:0] ERR_BAD_OP    = 3'd3;
    localparam logic [STAT_W-1:0] ERR_DIV_ZERO  = 3'd4;

    // Request from the sequencer to the divider.
    typedef struct packed {
        logic start;
        logic is_rem;
    } t_div_req;

    // Keeps the first error only.
    function automatic logic [STAT_W-1:0] note_error(input logic [STAT_W-1:0] cur,
                                                     input logic [STAT_W-1:0] code);
        note_error = (cur == ERR_NONE) ? code : cur;
    endfunction

endpackage

// ----- rtl/core/pee_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; no package needed.
module pee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/pee_div.sv -----
// Iterative signed divider: one quotient bit per cycle, truncating toward zero.
// Uses pee_pkg for widths and the request type.
module pee_div
    import pee_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_req          i_req,
    input  logic [DATA_W-1:0] i_dividend,
    input  logic [DATA_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DATA_W-1:0] o_result
);

    localparam int CNT_W = $clog2(DATA_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_dvs;
    logic              r_a_neg;
    logic              r_q_neg;
    logic              r_is_rem;

    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;

    // Trial subtraction for the current quotient bit.
    assign shifted = {r_rem, r_quo[DATA_W-1]};
    assign diff    = shifted - {1'b0, r_dvs};

    // Control state of the iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(DATA_W - 1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath: magnitudes on start, then shift and subtract.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem    <= '0;
            r_quo    <= i_dividend[DATA_W-1] ? (DATA_W'(0) - i_dividend) : i_dividend;
            r_dvs    <= i_divisor[DATA_W-1] ? (DATA_W'(0) - i_divisor) : i_divisor;
            r_a_neg  <= i_dividend[DATA_W-1];
            r_q_neg  <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
            r_is_rem <= i_req.is_rem;
        end else if (r_busy) begin
            if (!diff[DATA_W]) begin
                r_rem <= diff[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end
    end

    // Sign correction of the finished quotient or remainder.
    always_comb begin
        if (r_is_rem) begin
            o_result = r_a_neg ? (DATA_W'(0) - r_rem) : r_rem;
        end else begin
            o_result = r_q_neg ? (DATA_W'(0) - r_quo) : r_quo;
        end
    end

    assign o_done = r_done;

endmodule

// ----- rtl/core/prefix_expression_evaluator.sv -----
// Prefix expression evaluator: an operand stack in RAM driven by a sequencer.
// A digit is pushed; any other word pops two operands, computes and pushes a result, with
// / and % going through the 32-step divider, the worst case, unless the divisor is zero.
// A last word then pops the result and waits for the output register. One word at a time.
// Synchronous active-low reset empties the stack and clears status and the output
// valid; the stack RAM keeps its contents, which are never read before being written.
module prefix_expression_evaluator
    import pee_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [SYM_W-1:0]         i_symbol,
    input  logic                     i_last,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [DATA_W-1:0] o_value,
    output logic [STAT_W-1:0]        o_status
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_POPA,
        S_POPB,
        S_CALC,
        S_DIV,
        S_PUSH,
        S_FINAL,
        S_FINW,
        S_OUT
    } t_state;

    t_state             r_state, n_state;
    logic [DW-1:0]      r_depth, n_depth;
    logic [STAT_W-1:0]  r_err, n_err;
    logic [SYM_W-1:0]   r_sym, n_sym;
    logic               r_last, n_last;
    logic [DATA_W-1:0]  r_a, n_a;
    logic [DATA_W-1:0]  r_b, n_b;
    logic               r_b_rd, n_b_rd;
    logic               r_a_rd, n_a_rd;
    logic [DATA_W-1:0]  r_res, n_res;
    logic               r_ovalid, n_ovalid;
    logic [DATA_W-1:0]  r_value, n_value;
    logic [STAT_W-1:0]  r_status, n_status;

    logic               mem_we;
    logic [AW-1:0]      mem_raddr;
    logic [DATA_W-1:0]  mem_rdata;
    logic [DW-1:0]      depth_dec;
    logic [DATA_W-1:0]  opd_b;
    t_div_req           div_req;
    logic               div_done;
    logic [DATA_W-1:0]  div_result;

    // Operand stack storage.
    pee_ram #(
        .WIDTH(DATA_W),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(r_depth[AW-1:0]),
        .i_wdata(r_res),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    // Shared divider for / and %.
    pee_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (div_req),
        .i_dividend(r_a),
        .i_divisor (opd_b),
        .o_done    (div_done),
        .o_result  (div_result)
    );

    // The top of stack is always the entry below the depth.
    assign depth_dec = r_depth - 1'b1;
    assign mem_raddr = depth_dec[AW-1:0];
    assign opd_b     = r_b_rd ? mem_rdata : r_b;

    // Sequencer: next-state and datapath decisions.
    always_comb begin
        n_state  = r_state;
        n_depth  = r_depth;
        n_err    = r_err;
        n_sym    = r_sym;
        n_last   = r_last;
        n_a      = r_a;
        n_b      = r_b;
        n_a_rd   = r_a_rd;
        n_b_rd   = r_b_rd;
        n_res    = r_res;
        n_ovalid = r_ovalid;
        n_value  = r_value;
        n_status = r_status;
        mem_we   = 1'b0;
        div_req  = '0;

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_sym  = i_symbol;
                    n_last = i_last;
                    if (i_symbol inside {[CH_ZERO:CH_NINE]}) begin
                        n_res   = DATA_W'(i_symbol - CH_ZERO);
                        n_state = S_PUSH;
                    end else begin
                        n_state = S_POPA;
                    end
                end
            end
            S_POPA: begin
                if (r_depth == '0) begin
                    n_a    = '1;
                    n_a_rd = 1'b0;
                    n_err  = note_error(r_err, ERR_UNDERFLOW);
                end else begin
                    n_a_rd  = 1'b1;
                    n_depth = depth_dec;
                end
                n_state = S_POPB;
            end
            S_POPB: begin
                if (r_a_rd) begin
                    n_a = mem_rdata;
                end
                if (r_depth == '0) begin
                    n_b    = '1;
                    n_b_rd = 1'b0;
                    n_err  = note_error(r_err, ERR_UNDERFLOW);
                end else begin
                    n_b_rd  = 1'b1;
                    n_depth = depth_dec;
                end
                n_state = S_CALC;
            end
            S_CALC: begin
                n_state = S_PUSH;
                case (r_sym)
                    CH_PLUS:  n_res = r_a + opd_b;
                    CH_MINUS: n_res = r_a - opd_b;
                    CH_STAR:  n_res = r_a * opd_b;
                    CH_SLASH, CH_PCT: begin
                        if (opd_b == '0) begin
                            n_res = '0;
                            n_err = note_error(r_err, ERR_DIV_ZERO);
                        end else begin
                            div_req.start  = 1'b1;
                            div_req.is_rem = (r_sym == CH_PCT);
                            n_state        = S_DIV;
                        end
                    end
                    default: begin
                        n_res = '0;
                        n_err = note_error(r_err, ERR_BAD_OP);
                    end
                endcase
            end
            S_DIV: begin
                if (div_done) begin
                    n_res   = div_result;
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (r_depth == DW'(STACK_DEPTH)) begin
                    n_err = note_error(r_err, ERR_OVERFLOW);
                end else begin
                    mem_we  = 1'b1;
                    n_depth = r_depth + 1'b1;
                end
                n_state = r_last ? S_FINAL : S_IDLE;
            end
            S_FINAL: begin
                if (r_depth == '0) begin
                    n_res   = '1;
                    n_err   = note_error(r_err, ERR_UNDERFLOW);
                    n_state = S_OUT;
                end else begin
                    n_depth = depth_dec;
                    n_state = S_FINW;
                end
            end
            S_FINW: begin
                n_res   = mem_rdata;
                n_state = S_OUT;
            end
            S_OUT: begin
                // Hand the result to the output register once it is free.
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_value  = r_res;
                    n_status = r_err;
                    n_depth  = '0;
                    n_err    = ERR_NONE;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, stack pointer, status and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_depth  <= '0;
            r_err    <= ERR_NONE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_depth  <= n_depth;
            r_err    <= n_err;
            r_ovalid <= n_ovalid;
        end
        r_sym    <= n_sym;
        r_last   <= n_last;
        r_a      <= n_a;
        r_b      <= n_b;
        r_a_rd   <= n_a_rd;
        r_b_rd   <= n_b_rd;
        r_res    <= n_res;
        r_value  <= n_value;
        r_status <= n_status;
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_ovalid;
    assign o_value  = $signed(r_value);
    assign o_status = r_status;

endmodule

// ----- rtl/core/pee_checker.sv -----
// Port-level checks for the prefix expression evaluator, bound to the top level.
// Uses pee_pkg for widths and status codes.
module pee_checker
    import pee_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_valid,
    input logic                     o_ready,
    input logic [SYM_W-1:0]         i_symbol,
    input logic                     i_last,
    input logic                     o_valid,
    input logic                     i_ready,
    input logic signed [DATA_W-1:0] o_value,
    input logic [STAT_W-1:0]        o_status
);

    // A stalled result word holds its value and status.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_value) && $stable(o_status))
        else $error("result word changed while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Status carries only defined codes.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ERR_NONE) || (o_status == ERR_UNDERFLOW) ||
                    (o_status == ERR_OVERFLOW) || (o_status == ERR_BAD_OP) ||
                    (o_status == ERR_DIV_ZERO))
        else $error("undefined status code");

    // Ready drops once a symbol word is taken.
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("symbol word taken in consecutive cycles");

    // A word that is a digit and not last never yields a result on its own.
    a_digit_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !i_last && (i_symbol >= CH_ZERO) && (i_symbol <= CH_NINE)
        && !o_valid |=> !o_valid)
        else $error("result appeared after a plain digit");

endmodule

bind prefix_expression_evaluator pee_checker u_pee_checker (.*);

// ----- verif/tb.sv -----
// Self-checking testbench for the prefix expression evaluator.
// Drives symbol words through a valid/ready channel and checks each result word
// against a stack predictor kept here. Depends on pee_pkg and the evaluator RTL.
module tb;
    import pee_pkg::*;

    localparam int DEPTH        = STACK_DEPTH_DEF;
    localparam int QUIET_LIMIT  = 2000;
    localparam int PHASE_WORDS  = 341;
    localparam int TAIL_CYCLES  = 60;

    // One result word, and one row of the directed table.
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [STAT_W-1:0] status;
    } t_result;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             last;
        logic             typed;
        t_result          expected;
    } t_row;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             last;
    } t_word;

    typedef enum int {
        SEQ_WELL,
        SEQ_DEEP,
        SEQ_MINDIV,
        SEQ_NOISE,
        SEQ_BROKEN
    } t_seq_kind;

    // Directed words. Rows marked typed carry a result that is obvious by hand;
    // the others are left to the predictor.
    localparam t_row DIRECTED [27] = '{
        // Single digits at both ends of the range, straight after reset.
        '{CH_ZERO,          1'b1, 1'b1, '{32'd0, ERR_NONE}},
        '{CH_NINE,          1'b1, 1'b1, '{32'd9, ERR_NONE}},
        // Addition: 2 + 3.
        '{CH_ZERO + 8'd3,   1'b0, 1'b0, '{32'd0, ERR_NONE}},
        '{CH_ZERO + 8'd2,   1'b0, 1'b0, '{32'd0, ERR_NONE}},
        '{CH_PLUS,          1'b1, 1'b1, '{32'd5, ERR_NONE}},
        // Subtraction going negative: 2 - 7.
        '{CH_ZERO + 8'd7,   1'b0, 1'b0, '{32'd0, ERR_NONE}},
        '{CH_ZERO + 8'd2,   1'b0, 1'b0, '{32'd0, ERR_NONE}},
        '{CH_MINUS,         1'b1, 1'b1, '{-32'sd5, ERR_NONE}},
        // Multiplication: 9 * 9.
        '{CH_NINE,          1'b0, 1'b0, '{32'd0, ERR_NONE}},
        '{CH_NINE,          1'b0, 1'b0, '{32'd0, ERR_NONE}},
        '{CH_STAR,          1'b1, 1'b1, '{32'd81, ERR_NONE}},
        // Truncating division: 7 / 2.
        '{CH_ZERO + 8'd2,   1'b0, 1'b0, '{32'd0, ERR_NONE}},
        '{CH_ZERO + 8'd7,   1'b0, 1'b0, '{32'd0, ERR_NONE}},
        '{CH_SLASH,         1'b1, 1'b1, '{32'd3, ERR_NONE}},
        // Remainder by zero.
        '{CH_ZERO,          1'b0, 1'b0, '{32'd0, ERR_NONE}},
        '{CH_ZERO + 8'd7,   1'b0, 1'b0, '{32'd0, ERR_NONE}},
        '{CH_PCT,           1'b1, 1'b1, '{32'd0, ERR_DIV_ZERO}},
        // Unknown operator, lowest symbol code.
        '{CH_ZERO + 8'd1,   1'b0, 1'b0, '{32'd0, ERR_NONE}},
        '{CH_ZERO + 8'd2,   1'b0, 1'b0, '{32'd0, ERR_NONE}},
        '{8'h00,            1'b1, 1'b1, '{32'd0, ERR_BAD_OP}},
        // Operators on an empty stack: underflow wins over a bad operator.
        '{CH_PLUS,          1'b1, 1'b1, '{-32'sd2, ERR_UNDERFLOW}},
        '{8'hFF,            1'b1, 1'b1, '{32'd0, ERR_UNDERFLOW}},
        // Remainder of a negative dividend: (0 - 7) % 3.
        '{CH_ZERO + 8'd3,   1'b0, 1'b0, '{32'd0, ERR_NONE}},
        '{CH_ZERO + 8'd7,   1'b0, 1'b0, '{32'd0, ERR_NONE}},
        '{CH_ZERO,          1'b0, 1'b0, '{32'd0, ERR_NONE}},
        '{CH_MINUS,         1'b0, 1'b0, '{32'd0, ERR_NONE}},
        '{CH_PCT,           1'b1, 1'b0, '{32'd0, ERR_NONE}}
    };

    // Block ports.
    logic                     i_clk;
    logic                     i_rst_n  = 1'b0;
    logic                     i_valid  = 1'b0;
    logic                     o_ready;
    logic [SYM_W-1:0]         i_symbol = '0;
    logic                     i_last   = 1'b0;
    logic                     o_valid;
    logic                     i_ready  = 1'b0;
    logic signed [DATA_W-1:0] o_value;
    logic [STAT_W-1:0]        o_status;

    // Predictor state: operand stack and first fault since the last result.
    logic [DATA_W-1:0] operand_mem [DEPTH];
    int unsigned       operand_count = 0;
    logic [STAT_W-1:0] first_fault   = ERR_NONE;

    t_result     pending_results [$];
    t_word       expr_q [$];
    logic        typed_now    = 1'b0;
    t_result     typed_result = '0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned words_sent    = 0;
    int unsigned results_checked = 0;
    int unsigned error_count   = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned deep_runs     = 0;
    int unsigned mindiv_runs   = 0;
    int unsigned status_hits [8];

    prefix_expression_evaluator #(
        .STACK_DEPTH(DEPTH)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_symbol (i_symbol),
        .i_last   (i_last),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_value  (o_value),
        .o_status (o_status)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Only the first fault since the last result is kept.
    function automatic void note_fault(input logic [STAT_W-1:0] code);
        if (first_fault == ERR_NONE) begin
            first_fault = code;
        end
    endfunction

    function automatic void push_operand(input logic [DATA_W-1:0] v);
        if (operand_count >= DEPTH) begin
            note_fault(ERR_OVERFLOW);
        end else begin
            operand_mem[operand_count] = v;
            operand_count++;
        end
    endfunction

    function automatic logic [DATA_W-1:0] pop_operand();
        if (operand_count == 0) begin
            note_fault(ERR_UNDERFLOW);
            return '1;
        end
        operand_count--;
        return operand_mem[operand_count];
    endfunction

    // Applies one symbol word to the stack and reports the result word it causes.
    function automatic void predict_word(input logic [SYM_W-1:0] sym, input logic last,
                                         output logic emits, output t_result res);
        logic [DATA_W-1:0] lhs, rhs, mag_l, mag_r, outcome;
        emits = 1'b0;
        res   = '0;
        if (sym >= CH_ZERO && sym <= CH_NINE) begin
            push_operand(32'(sym - CH_ZERO));
        end else begin
            lhs = pop_operand();
            rhs = pop_operand();
            case (sym)
                CH_PLUS:  outcome = lhs + rhs;
                CH_MINUS: outcome = lhs - rhs;
                CH_STAR:  outcome = lhs * rhs;
                CH_SLASH, CH_PCT: begin
                    if (rhs == '0) begin
                        note_fault(ERR_DIV_ZERO);
                        outcome = '0;
                    end else begin
                        // Work on magnitudes so that the most negative value wraps.
                        mag_l = lhs[DATA_W-1] ? -lhs : lhs;
                        mag_r = rhs[DATA_W-1] ? -rhs : rhs;
                        if (sym == CH_SLASH) begin
                            outcome = mag_l / mag_r;
                            if (lhs[DATA_W-1] != rhs[DATA_W-1]) outcome = -outcome;
                        end else begin
                            outcome = mag_l % mag_r;
                            if (lhs[DATA_W-1]) outcome = -outcome;
                        end
                    end
                end
                default: begin
                    note_fault(ERR_BAD_OP);
                    outcome = '0;
                end
            endcase
            push_operand(outcome);
        end
        if (last) begin
            res.value     = pop_operand();
            res.status    = first_fault;
            emits         = 1'b1;
            operand_count = 0;
            first_fault   = ERR_NONE;
        end
    endfunction

    // Monitor: predicts on each accepted symbol word, checks each result word,
    // and ends the run if the channels go quiet for too long.
    always @(posedge i_clk) begin
        logic    emits;
        t_result predicted;
        t_result oldest;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                predict_word(i_symbol, i_last, emits, predicted);
                if (emits) begin
                    pending_results.push_back(typed_now ? typed_result : predicted);
                end
            end
            if (o_valid && i_ready) begin
                results_checked++;
                status_hits[o_status]++;
                if (pending_results.size() == 0) begin
                    $error("result word with none expected: value %0d, status %0d",
                           o_value, o_status);
                    error_count++;
                end else begin
                    oldest = pending_results.pop_front();
                    if (o_value !== oldest.value) begin
                        $error("value: expected %0d, got %0d",
                               $signed(oldest.value), o_value);
                        error_count++;
                    end
                    if (o_status !== oldest.status) begin
                        $error("status: expected %0d, got %0d", oldest.status, o_status);
                        error_count++;
                    end
                end
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    // Result side: stalls at random at the current rate.
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Presents one symbol word, with random gaps, and waits for it to be taken.
    task automatic send_word(input logic [SYM_W-1:0] sym, input logic last,
                             input logic typed, input t_result expected);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_symbol     <= sym;
        i_last       <= last;
        typed_now    <= typed;
        typed_result <= expected;
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
    endtask

    function automatic void append_symbol(input logic [SYM_W-1:0] sym);
        t_word w;
        w.sym  = sym;
        w.last = 1'b0;
        expr_q.push_back(w);
    endfunction

    function automatic logic [SYM_W-1:0] pick_digit();
        return ($urandom_range(4) == 0) ? CH_ZERO : CH_ZERO + 8'($urandom_range(9));
    endfunction

    // Mostly the five operators, now and then an unknown character.
    function automatic logic [SYM_W-1:0] pick_operator();
        logic [SYM_W-1:0] sym;
        if ($urandom_range(19) == 0) begin
            do begin
                sym = 8'($urandom_range(255));
            end while ((sym >= CH_ZERO && sym <= CH_NINE) ||
                       (sym inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT}));
            return sym;
        end
        case ($urandom_range(4))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            3:       return CH_SLASH;
            default: return CH_PCT;
        endcase
    endfunction

    // Builds a well-formed reversed prefix expression with n_ops operators.
    // With digits_first set, every operand is pushed before any operator.
    function automatic void build_expression(input int unsigned n_ops,
                                             input logic digits_first);
        int unsigned digits_left, ops_left, depth;
        digits_left = n_ops + 1;
        ops_left    = n_ops;
        depth       = 0;
        while (digits_left + ops_left > 0) begin
            if (ops_left > 0 && depth >= 2 &&
                (digits_left == 0 || (!digits_first && $urandom_range(1) == 1))) begin
                append_symbol(pick_operator());
                ops_left--;
                depth--;
            end else begin
                append_symbol(pick_digit());
                digits_left--;
                depth++;
            end
        end
    endfunction

    // Builds one sequence of the given kind and sends it.
    task automatic run_sequence(input t_seq_kind kind);
        int unsigned n;
        expr_q.delete();
        case (kind)
            SEQ_WELL: begin
                n = ($urandom_range(9) == 0) ? $urandom_range(6, 15) : $urandom_range(0, 5);
                build_expression(n, 1'b0);
            end
            SEQ_DEEP: begin
                // Alternates between overflowing the stack and filling it exactly.
                n = (deep_runs % 2 == 0) ? $urandom_range(DEPTH + 1, DEPTH + 8) : DEPTH;
                deep_runs++;
                build_expression(n - 1, 1'b1);
            end
            SEQ_MINDIV: begin
                // Divisor 0 - 1, then the most negative value as 2 * 8^10.
                append_symbol(CH_ZERO + 8'd1);
                append_symbol(CH_ZERO);
                append_symbol(CH_MINUS);
                append_symbol(CH_ZERO + 8'd2);
                repeat (10) begin
                    append_symbol(CH_ZERO + 8'd8);
                    append_symbol(CH_STAR);
                end
                append_symbol((mindiv_runs % 2 == 0) ? CH_SLASH : CH_PCT);
                mindiv_runs++;
            end
            SEQ_NOISE: begin
                repeat ($urandom_range(1, 6)) begin
                    append_symbol(8'($urandom_range(255)));
                    expr_q[expr_q.size()-1].last = ($urandom_range(3) == 0);
                end
            end
            default: begin
                // A missing operand or a spare operator.
                build_expression($urandom_range(1, 4), 1'b0);
                if ($urandom_range(1) == 1) begin
                    void'(expr_q.pop_front());
                end else begin
                    append_symbol(pick_operator());
                end
            end
        endcase
        if (kind != SEQ_NOISE) begin
            expr_q[expr_q.size()-1].last = 1'b1;
        end
        foreach (expr_q[i]) begin
            send_word(expr_q[i].sym, expr_q[i].last, 1'b0, '0);
        end
    endtask

    // Stimulus: reset, directed table, then three phases of random sequences, idling in the first two.
    initial begin
        int unsigned phase_goal;
        int unsigned pick;
        send_idle_pct = 25;
        recv_idle_pct = 79;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i]) begin
            send_word(DIRECTED[i].sym, DIRECTED[i].last, DIRECTED[i].typed,
                      DIRECTED[i].expected);
        end

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 79 : 0;
            recv_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 25 : 0;
            phase_goal    = words_sent + PHASE_WORDS;
            run_sequence(SEQ_DEEP);
            run_sequence(SEQ_MINDIV);
            while (words_sent < phase_goal) begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    run_sequence(SEQ_WELL);
                end else if (pick < 72) begin
                    run_sequence(SEQ_DEEP);
                end else if (pick < 74) begin
                    run_sequence(SEQ_MINDIV);
                end else if (pick < 86) begin
                    run_sequence(SEQ_NOISE);
                end else begin
                    run_sequence(SEQ_BROKEN);
                end
            end
        end

        // Drain, then allow for a word still being worked on that gives no result.
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d result words never arrived", pending_results.size());
            error_count++;
        end

        $display("summary: %0d symbol words sent, %0d result words checked",
                 words_sent, results_checked);
        $display("summary: ok %0d, underflow %0d, overflow %0d, bad op %0d, div zero %0d",
                 status_hits[ERR_NONE], status_hits[ERR_UNDERFLOW],
                 status_hits[ERR_OVERFLOW], status_hits[ERR_BAD_OP],
                 status_hits[ERR_DIV_ZERO]);
        if (error_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
